>>> hdl/pidc_pkg.sv
// Shared widths, register codes, state encoding and status types of the clamped PID block.
package pidc_pkg;

  localparam int DATA_W    = 16;
  localparam int ERR_W     = DATA_W + 1;
  localparam int DIFF_W    = DATA_W + 2;
  localparam int FRAC_DT   = 12;
  localparam int FRAC_GAIN = 8;
  localparam int NUM_W     = DIFF_W + FRAC_DT;
  localparam int QUO_W     = NUM_W;
  localparam int DER_W     = QUO_W + 1;
  localparam int INTEG_W   = 32;
  localparam int ISUM_W    = INTEG_W + 2;
  localparam int DTPROD_W  = ERR_W + DATA_W;
  localparam int PP_W      = ERR_W + DATA_W;
  localparam int PI_W      = INTEG_W + DATA_W;
  localparam int PD_W      = DER_W + DATA_W;
  localparam int SUM_W     = 48;
  localparam int MUL_STEPS = DATA_W;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
  localparam int DCNT_W    = $clog2(NUM_W);
  localparam int CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P  = 3'd0,
    CFG_GAIN_I  = 3'd1,
    CFG_GAIN_D  = 3'd2,
    CFG_OUT_MAX = 3'd3,
    CFG_OUT_MIN = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INTEG,
    ST_GAIN,
    ST_SUM,
    ST_ADD_D,
    ST_CLAMP
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/pidc_div.sv
// Bit-serial restoring divider for the derivative term, one quotient bit per cycle.
module pidc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pidc_pkg::NUM_W-1:0]      dividend,
  input  logic [pidc_pkg::DATA_W-1:0]     divisor,
  output pidc_pkg::div_stat_t             stat,
  output logic [pidc_pkg::QUO_W-1:0]      quotient
);

  logic [pidc_pkg::DCNT_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [pidc_pkg::NUM_W-1:0]  num;
  logic [pidc_pkg::DATA_W-1:0] rem;
  logic [pidc_pkg::QUO_W-1:0]  quo;
  logic [pidc_pkg::DATA_W:0]   shifted;
  logic [pidc_pkg::DATA_W+1:0] trial;
  logic                        fits;

  assign shifted = {rem, num[pidc_pkg::NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = !trial[pidc_pkg::DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pidc_pkg::DCNT_W'(pidc_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[pidc_pkg::NUM_W-2:0], 1'b0};
      rem <= fits ? trial[pidc_pkg::DATA_W-1:0] : shifted[pidc_pkg::DATA_W-1:0];
      quo <= {quo[pidc_pkg::QUO_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

>>> hdl/pid_controller_clamped.sv
// Top level of the clamped PID controller with serial multiply and divide datapath.
//
//   channel   direction   handshake                 payload
//   in        input       in_valid / in_stall       target, measured, time_step
//   out       output      out_valid / out_stall     drive
//   cfg       input       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A step runs from its input beat to the next free input slot.
// The serial divider sets most of it: 30 quotient bits, one per cycle, while
// the error times time step product runs alongside; the three gain products
// then follow, one gain bit per cycle, and after them two adds and the clamp.
// Reset clears the state, the gains to zero and the limits to their full range.
// A finished result sits in the output register while the next beat is taken;
// the clamp stage waits only if that register is still stalled.
module pid_controller_clamped (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pidc_pkg::DATA_W-1:0]  target,
  input  logic signed [pidc_pkg::DATA_W-1:0]  measured,
  input  logic [pidc_pkg::DATA_W-1:0]         time_step,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pidc_pkg::DATA_W-1:0]  drive,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]         cfg_data
);

  pidc_pkg::state_t state;
  pidc_pkg::state_t state_next;

  logic signed [pidc_pkg::DATA_W-1:0]   gain_p;
  logic signed [pidc_pkg::DATA_W-1:0]   gain_i;
  logic signed [pidc_pkg::DATA_W-1:0]   gain_d;
  logic signed [pidc_pkg::DATA_W-1:0]   out_max;
  logic signed [pidc_pkg::DATA_W-1:0]   out_min;
  logic signed [pidc_pkg::ERR_W-1:0]    last_error;
  logic signed [pidc_pkg::INTEG_W-1:0]  error_sum;

  logic signed [pidc_pkg::ERR_W-1:0]    err;
  logic [pidc_pkg::DATA_W-1:0]          dt;
  logic [pidc_pkg::DATA_W-1:0]          dt_sh;
  logic                                 diff_neg;
  logic signed [pidc_pkg::DTPROD_W-1:0] dt_prod;
  logic signed [pidc_pkg::DER_W-1:0]    deriv;
  logic [pidc_pkg::MCNT_W-1:0]          mcnt;
  logic [pidc_pkg::DATA_W-1:0]          gp_sh;
  logic [pidc_pkg::DATA_W-1:0]          gi_sh;
  logic [pidc_pkg::DATA_W-1:0]          gd_sh;
  logic signed [pidc_pkg::PP_W-1:0]     prod_p;
  logic signed [pidc_pkg::PI_W-1:0]     prod_i;
  logic signed [pidc_pkg::PD_W-1:0]     prod_d;
  logic signed [pidc_pkg::SUM_W-1:0]    sum;

  logic                                 in_accept;
  logic                                 div_start;
  logic                                 out_load;
  logic signed [pidc_pkg::ERR_W-1:0]    err_now;
  logic signed [pidc_pkg::DIFF_W-1:0]   diff_now;
  logic [pidc_pkg::DIFF_W-1:0]          diff_mag;
  logic [pidc_pkg::NUM_W-1:0]           dividend;
  logic [pidc_pkg::QUO_W-1:0]           quotient;
  pidc_pkg::div_stat_t                  div_stat;
  logic signed [pidc_pkg::DTPROD_W-1:0] dt_x;
  logic signed [pidc_pkg::PP_W-1:0]     pp_x;
  logic signed [pidc_pkg::PI_W-1:0]     pi_x;
  logic signed [pidc_pkg::PD_W-1:0]     pd_x;
  logic signed [pidc_pkg::ISUM_W-1:0]   integ_sum;
  logic signed [pidc_pkg::INTEG_W-1:0]  integ_sat;
  logic signed [pidc_pkg::DER_W-1:0]    deriv_c;
  logic signed [pidc_pkg::SUM_W-1:0]    lim_hi;
  logic signed [pidc_pkg::SUM_W-1:0]    lim_lo;
  logic signed [pidc_pkg::SUM_W-1:0]    rounded;
  logic signed [pidc_pkg::DATA_W-1:0]   drive_c;
  logic                                 dt_step;
  logic                                 last_gain_step;

  assign cfg_ready = 1'b1;

  assign err_now  = {target[pidc_pkg::DATA_W-1], target}
                  - {measured[pidc_pkg::DATA_W-1], measured};
  assign diff_now = {err_now[pidc_pkg::ERR_W-1], err_now}
                  - {last_error[pidc_pkg::ERR_W-1], last_error};
  assign diff_mag = diff_now[pidc_pkg::DIFF_W-1] ? -diff_now : diff_now;
  assign dividend = {diff_mag, {pidc_pkg::FRAC_DT{1'b0}}};

  pidc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dt),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign dt_step        = mcnt < pidc_pkg::MCNT_W'(pidc_pkg::MUL_STEPS);
  assign last_gain_step = mcnt == pidc_pkg::MCNT_W'(pidc_pkg::MUL_STEPS - 1);

  assign dt_x = {{(pidc_pkg::DTPROD_W - pidc_pkg::ERR_W){err[pidc_pkg::ERR_W-1]}}, err};
  assign pp_x = {{(pidc_pkg::PP_W - pidc_pkg::ERR_W){err[pidc_pkg::ERR_W-1]}}, err};
  assign pi_x = {{(pidc_pkg::PI_W - pidc_pkg::INTEG_W){error_sum[pidc_pkg::INTEG_W-1]}},
                 error_sum};
  assign pd_x = {{(pidc_pkg::PD_W - pidc_pkg::DER_W){deriv[pidc_pkg::DER_W-1]}}, deriv};

  assign integ_sum = {{2{error_sum[pidc_pkg::INTEG_W-1]}}, error_sum}
                   + {dt_prod[pidc_pkg::DTPROD_W-1], dt_prod};

  always_comb begin
    integ_sat = integ_sum[pidc_pkg::INTEG_W-1:0];
    if (!integ_sum[pidc_pkg::ISUM_W-1] &&
        (integ_sum[pidc_pkg::ISUM_W-2:pidc_pkg::INTEG_W-1] != '0)) begin
      integ_sat = {1'b0, {(pidc_pkg::INTEG_W-1){1'b1}}};
    end else if (integ_sum[pidc_pkg::ISUM_W-1] &&
                 (integ_sum[pidc_pkg::ISUM_W-2:pidc_pkg::INTEG_W-1] != '1)) begin
      integ_sat = {1'b1, {(pidc_pkg::INTEG_W-1){1'b0}}};
    end
  end

  always_comb begin
    deriv_c = '0;
    if (dt != '0) begin
      deriv_c = diff_neg ? -{1'b0, quotient} : {1'b0, quotient};
    end
  end

  assign lim_hi = {{(pidc_pkg::SUM_W - pidc_pkg::DATA_W - pidc_pkg::FRAC_GAIN)
                    {out_max[pidc_pkg::DATA_W-1]}}, out_max, {pidc_pkg::FRAC_GAIN{1'b0}}};
  assign lim_lo = {{(pidc_pkg::SUM_W - pidc_pkg::DATA_W - pidc_pkg::FRAC_GAIN)
                    {out_min[pidc_pkg::DATA_W-1]}}, out_min, {pidc_pkg::FRAC_GAIN{1'b0}}};
  assign rounded = sum + pidc_pkg::SUM_W'(1 << (pidc_pkg::FRAC_GAIN - 1));

  always_comb begin
    if (sum > lim_hi) begin
      drive_c = out_max;
    end else if (sum < lim_lo) begin
      drive_c = out_min;
    end else begin
      drive_c = rounded[pidc_pkg::FRAC_GAIN +: pidc_pkg::DATA_W];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pidc_pkg::ST_IDLE: begin
        if (in_valid) state_next = pidc_pkg::ST_DIV;
      end
      pidc_pkg::ST_DIV: begin
        if (div_stat.done) state_next = pidc_pkg::ST_INTEG;
      end
      pidc_pkg::ST_INTEG: state_next = pidc_pkg::ST_GAIN;
      pidc_pkg::ST_GAIN: begin
        if (last_gain_step) state_next = pidc_pkg::ST_SUM;
      end
      pidc_pkg::ST_SUM:   state_next = pidc_pkg::ST_ADD_D;
      pidc_pkg::ST_ADD_D: state_next = pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_CLAMP: begin
        if (!out_valid || !out_stall) state_next = pidc_pkg::ST_IDLE;
      end
      default: state_next = pidc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_load  = 1'b0;
    case (state)
      pidc_pkg::ST_IDLE:  in_stall = 1'b0;
      pidc_pkg::ST_CLAMP: out_load = !out_valid || !out_stall;
      default: begin
        in_stall = 1'b1;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign div_start = in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pidc_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      last_error <= '0;
      error_sum  <= '0;
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      out_max    <= pidc_pkg::OUT_MAX_RST;
      out_min    <= pidc_pkg::OUT_MIN_RST;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) last_error <= err_now;
      if (state == pidc_pkg::ST_INTEG) error_sum <= integ_sat;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pidc_pkg::CFG_GAIN_P:  gain_p  <= cfg_data;
          pidc_pkg::CFG_GAIN_I:  gain_i  <= cfg_data;
          pidc_pkg::CFG_GAIN_D:  gain_d  <= cfg_data;
          pidc_pkg::CFG_OUT_MAX: out_max <= cfg_data;
          pidc_pkg::CFG_OUT_MIN: out_min <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      err      <= err_now;
      dt       <= time_step;
      dt_sh    <= time_step;
      diff_neg <= diff_now[pidc_pkg::DIFF_W-1];
      dt_prod  <= '0;
      mcnt     <= '0;
    end else begin
      case (state)
        pidc_pkg::ST_DIV: begin
          if (dt_step) begin
            dt_prod <= (dt_prod <<< 1) + (dt_sh[pidc_pkg::DATA_W-1] ? dt_x : '0);
            dt_sh   <= {dt_sh[pidc_pkg::DATA_W-2:0], 1'b0};
            mcnt    <= mcnt + 1'b1;
          end
          if (div_stat.done) deriv <= deriv_c;
        end
        pidc_pkg::ST_INTEG: begin
          mcnt  <= '0;
          gp_sh <= gain_p;
          gi_sh <= gain_i;
          gd_sh <= gain_d;
        end
        pidc_pkg::ST_GAIN: begin
          if (mcnt == '0) begin
            prod_p <= gp_sh[pidc_pkg::DATA_W-1] ? -pp_x : '0;
            prod_i <= gi_sh[pidc_pkg::DATA_W-1] ? -pi_x : '0;
            prod_d <= gd_sh[pidc_pkg::DATA_W-1] ? -pd_x : '0;
          end else begin
            prod_p <= (prod_p <<< 1) + (gp_sh[pidc_pkg::DATA_W-1] ? pp_x : '0);
            prod_i <= (prod_i <<< 1) + (gi_sh[pidc_pkg::DATA_W-1] ? pi_x : '0);
            prod_d <= (prod_d <<< 1) + (gd_sh[pidc_pkg::DATA_W-1] ? pd_x : '0);
          end
          gp_sh <= {gp_sh[pidc_pkg::DATA_W-2:0], 1'b0};
          gi_sh <= {gi_sh[pidc_pkg::DATA_W-2:0], 1'b0};
          gd_sh <= {gd_sh[pidc_pkg::DATA_W-2:0], 1'b0};
          mcnt  <= mcnt + 1'b1;
        end
        pidc_pkg::ST_SUM: begin
          sum <= {{(pidc_pkg::SUM_W - pidc_pkg::PP_W){prod_p[pidc_pkg::PP_W-1]}}, prod_p}
               + {{(pidc_pkg::SUM_W - pidc_pkg::PI_W + pidc_pkg::FRAC_DT)
                   {prod_i[pidc_pkg::PI_W-1]}}, prod_i[pidc_pkg::PI_W-1:pidc_pkg::FRAC_DT]};
        end
        pidc_pkg::ST_ADD_D: begin
          sum <= sum
               + {{(pidc_pkg::SUM_W - pidc_pkg::PD_W){prod_d[pidc_pkg::PD_W-1]}}, prod_d};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) drive <= drive_c;
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat taken while a step was still running");

  a_result_from_clamp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == pidc_pkg::ST_CLAMP))
    else $error("result appeared outside the clamp stage");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == pidc_pkg::ST_DIV)
    else $error("divider finished outside the divide phase");

  a_gain_phase: assert property (@(posedge clk) disable iff (rst)
    state == pidc_pkg::ST_GAIN |=> state == pidc_pkg::ST_GAIN || state == pidc_pkg::ST_SUM)
    else $error("gain phase left to an unexpected state");

endmodule

>>> test/pid_controller_clamped_tb.sv
// Self-checking testbench for the clamped PID controller with a built-in step predictor.
module pid_controller_clamped_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [pidc_pkg::DATA_W-1:0] sample_t;
  typedef logic [pidc_pkg::DATA_W-1:0] dt_t;

  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_MIN = 16'sh8000;

  class drive_scoreboard;
    logic signed [pidc_pkg::ERR_W-1:0] prev_err;
    logic signed [pidc_pkg::INTEG_W-1:0] integral;
    sample_t kp, ki, kd, lim_hi, lim_lo;
    sample_t drive_q[$];
    int mismatches;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      lim_hi = pidc_pkg::OUT_MAX_RST;
      lim_lo = pidc_pkg::OUT_MIN_RST;
      prev_err = '0;
      integral = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                            logic [pidc_pkg::DATA_W-1:0] val);
      case (idx)
        pidc_pkg::CFG_GAIN_P: kp = val;
        pidc_pkg::CFG_GAIN_I: ki = val;
        pidc_pkg::CFG_GAIN_D: kd = val;
        pidc_pkg::CFG_OUT_MAX: lim_hi = val;
        pidc_pkg::CFG_OUT_MIN: lim_lo = val;
        default: ;
      endcase
    endfunction

    function void note_step(sample_t t, sample_t m, dt_t dt);
      longint e, acc, rate, total, res;
      e = longint'(t) - longint'(m);
      acc = longint'(integral) + e * longint'(dt);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      integral = acc[pidc_pkg::INTEG_W-1:0];
      rate = 0;
      if (dt != '0) rate = ((e - longint'(prev_err)) * 4096) / longint'(dt);
      total = longint'(kp) * e
            + ((longint'(ki) * longint'(integral)) >>> pidc_pkg::FRAC_DT)
            + longint'(kd) * rate;
      if (total > longint'(lim_hi) * 256) res = longint'(lim_hi);
      else if (total < longint'(lim_lo) * 256) res = longint'(lim_lo);
      else res = (total + 128) >>> pidc_pkg::FRAC_GAIN;
      prev_err = e[pidc_pkg::ERR_W-1:0];
      drive_q.push_back(res[pidc_pkg::DATA_W-1:0]);
    endfunction

    function void flag(string what, sample_t want, sample_t got);
      if (mismatches < 10)
        $display("Mismatch (%s): expected drive %0d, got %0d", what, want, got);
      mismatches++;
    endfunction

    function void check_drive(sample_t got);
      sample_t want;
      if (drive_q.size() == 0) begin
        flag("beat with nothing expected", '0, got);
      end else begin
        want = drive_q.pop_front();
        if (got !== want) flag("wrong value", want, got);
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t target = '0;
  sample_t measured = '0;
  dt_t time_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t drive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pidc_pkg::DATA_W-1:0] cfg_data = '0;

  drive_scoreboard sb = new();
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  int rx_wait = 0;
  int rx_hold = 0;
  int results_seen = 0;

  pid_controller_clamped dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .target(target),
    .measured(measured),
    .time_step(time_step),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive(drive),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver holds off for a long stretch twice so that the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_drive(drive);
        results_seen++;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 10);
        if (results_seen == 100 || results_seen == 350) rx_hold = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_step(sample_t t, sample_t m, dt_t dt);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target <= t;
    measured <= m;
    time_step <= dt;
    do @(posedge clk); while (in_stall);
    sb.note_step(t, m, dt);
  endtask

  task automatic send_random();
    sample_t t, m;
    dt_t dt;
    t = sample_t'($urandom);
    case ($urandom_range(0, 3))
      0, 1: m = t + sample_t'($urandom_range(0, 600) - 300);
      default: m = sample_t'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: dt = '0;
      1: dt = '1;
      2, 3, 4, 5: dt = dt_t'($urandom_range(1, 4096));
      default: dt = dt_t'($urandom);
    endcase
    send_step(t, m, dt);
  endtask

  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pidc_pkg::DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // A write to an index past the last register is expected to be ignored.
  task automatic configure(sample_t gp, sample_t gi, sample_t gd, sample_t hi, sample_t lo);
    write_reg(pidc_pkg::CFG_GAIN_P, gp);
    write_reg(pidc_pkg::CFG_GAIN_I, gi);
    write_reg(pidc_pkg::CFG_GAIN_D, gd);
    write_reg(pidc_pkg::CFG_OUT_MAX, hi);
    write_reg(pidc_pkg::CFG_OUT_MIN, lo);
    write_reg(pidc_pkg::CFG_IDX_W'($urandom_range(int'(pidc_pkg::CFG_OUT_MIN) + 1,
                                                   (1 << pidc_pkg::CFG_IDX_W) - 1)),
              pidc_pkg::DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t small_gain();
    return sample_t'(int'($urandom_range(0, 1024)) - 512);
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(16'sd256, 16'sd64, 16'sd2, S_MAX, S_MIN);
    send_step(16'sd0, 16'sd0, 16'd4096);
    send_step(S_MAX, S_MIN, 16'd4096);
    send_step(S_MIN, S_MAX, 16'd4096);
    send_step(16'sd100, 16'sd0, 16'd0);
    send_step(16'sd100, 16'sd50, 16'd1);
    send_step(-16'sd5, 16'sd5, 16'hFFFF);
    send_step(S_MAX, S_MIN, 16'hFFFF);
    send_step(S_MAX, S_MIN, 16'hFFFF);
    send_step(S_MIN, S_MAX, 16'hFFFF);
    send_step(S_MIN, S_MAX, 16'hFFFF);
    send_step(16'sd0, 16'sd0, 16'd0);
    drain(8);

    configure(16'sd128, 16'sd0, 16'sd0, S_MAX, S_MIN);
    send_step(16'sd1, 16'sd0, 16'd4096);
    send_step(-16'sd1, 16'sd0, 16'd4096);
    send_step(16'sd3, 16'sd0, 16'd4096);
    send_step(-16'sd3, 16'sd0, 16'd4096);
    drain(8);

    configure(16'sd256, 16'sd0, 16'sd0, -16'sd100, 16'sd100);
    send_step(16'sd500, 16'sd0, 16'd4096);
    send_step(-16'sd100, 16'sd0, 16'd4096);
    send_step(-16'sd500, 16'sd0, 16'd4096);
    drain(8);

    for (int phase = 0; phase < 6; phase++) begin
      tx_fast = (phase % 3 == 1);
      rx_fast = (phase % 3 == 2);
      case (phase % 5)
        0: configure(small_gain(), small_gain(), small_gain(), S_MAX, S_MIN);
        1: configure(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                     sample_t'($urandom), sample_t'($urandom));
        2: configure(S_MIN, S_MAX, S_MIN, S_MIN, S_MAX);
        3: configure(small_gain(), small_gain(), small_gain(),
                     sample_t'($urandom_range(0, 3000)),
                     sample_t'(-int'($urandom_range(0, 3000))));
        default: configure(S_MAX, S_MIN, S_MAX, S_MAX, S_MIN);
      endcase
      for (int i = 0; i < 85; i++) begin
        if (i == 40) drain(0);
        send_random();
      end
      drain(8);
    end

    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
